[hw/rtl/kmte_pkg.sv]
package kmte_pkg;

  localparam int TIMER_BITS = 16;

  // configuration register indexes
  localparam logic CFG_TEXT_ENTRY_ALLOWED = 1'b0;
  localparam logic CFG_COMMIT_TIMEOUT     = 1'b1;

  localparam logic [15:0] COMMIT_TIMEOUT_RESET = 16'd1500;

  // key classes
  localparam logic [3:0] KEY_LAST_DIGIT = 4'd9;
  localparam logic [3:0] KEY_ERASE      = 4'd10;

  // result actions
  localparam logic [2:0] ACT_NONE        = 3'd0;
  localparam logic [2:0] ACT_SHOW        = 3'd1;
  localparam logic [2:0] ACT_COMMIT      = 3'd2;
  localparam logic [2:0] ACT_CANCEL      = 3'd3;
  localparam logic [2:0] ACT_COMMIT_SHOW = 3'd4;

  // characters each digit steps through, the digit itself last
  localparam logic [6:0] CYCLE_CHARS [0:9][0:4] = '{
    '{7'h20, 7'h30, 7'h00, 7'h00, 7'h00},
    '{7'h2e, 7'h2c, 7'h3f, 7'h21, 7'h31},
    '{7'h61, 7'h62, 7'h63, 7'h32, 7'h00},
    '{7'h64, 7'h65, 7'h66, 7'h33, 7'h00},
    '{7'h67, 7'h68, 7'h69, 7'h34, 7'h00},
    '{7'h6a, 7'h6b, 7'h6c, 7'h35, 7'h00},
    '{7'h6d, 7'h6e, 7'h6f, 7'h36, 7'h00},
    '{7'h70, 7'h71, 7'h72, 7'h73, 7'h37},
    '{7'h74, 7'h75, 7'h76, 7'h38, 7'h00},
    '{7'h77, 7'h78, 7'h79, 7'h7a, 7'h39}
  };

  localparam logic [2:0] CYCLE_LEN [0:9] = '{
    3'd2, 3'd5, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd5, 3'd4, 3'd5
  };

  typedef struct packed {
    logic       func;
    logic       is_press;
    logic [3:0] key_class;
    logic       auto_repeat;
  } kmte_item_t;

  typedef struct packed {
    logic       handled;
    logic [2:0] action;
    logic [6:0] shown_char;
  } kmte_result_t;

endpackage

[hw/rtl/kmte_item_if.sv]
interface kmte_item_if
  import kmte_pkg::*;
();
  logic       valid;
  logic       ready;
  kmte_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/kmte_result_if.sv]
interface kmte_result_if
  import kmte_pkg::*;
();
  logic         valid;
  logic         ready;
  kmte_result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/keypad_multitap_text_entry.sv]
// Multi-tap text entry: key events and time ticks come in on item, one result per
// item goes out on result. An item is taken every cycle that item.ready is high, and its
// result goes to the result register, or to the skid register while the result register
// holds an untaken result; this two-entry output buffer lets the input keep running while a
// result waits, so item.ready drops only when both entries hold untaken results.
// Configuration writes take effect at once and there is no clearing pass after reset.
module keypad_multitap_text_entry
  import kmte_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  kmte_item_if.sink           item,
  kmte_result_if.source       result,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data
);

  logic                  text_entry_allowed;
  logic [15:0]           commit_timeout;

  logic                  cycle_active, cycle_active_next;
  logic [3:0]            pending_key, pending_key_next;
  logic [2:0]            cycle_position, cycle_position_next;
  logic [TIMER_BITS-1:0] ticks_left, ticks_left_next;

  kmte_result_t          step_res;
  kmte_result_t          head, skid;
  logic                  head_valid, skid_valid;

  logic                  accept, pop, keypad, same_key;
  logic [2:0]            pos_inc;
  logic [2:0]            pos_new;

  assign item.ready   = !skid_valid;
  assign accept       = item.valid && item.ready;
  assign pop          = head_valid && result.ready;
  assign result.valid = head_valid;
  assign result.data  = head;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_entry_allowed <= 1'b1;
      commit_timeout     <= COMMIT_TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TEXT_ENTRY_ALLOWED: text_entry_allowed <= cfg_data[0];
        CFG_COMMIT_TIMEOUT:     commit_timeout     <= cfg_data;
      endcase
    end
  end

  assign keypad   = item.data.key_class <= KEY_LAST_DIGIT;
  assign same_key = cycle_active && (pending_key == item.data.key_class);
  assign pos_inc  = cycle_position + 3'd1;

  always_comb begin
    cycle_active_next   = cycle_active;
    pending_key_next    = pending_key;
    cycle_position_next = cycle_position;
    ticks_left_next     = ticks_left;
    step_res            = '{handled: 1'b0, action: ACT_NONE, shown_char: 7'd0};
    pos_new             = 3'd0;
    if (item.data.func) begin
      if (cycle_active) begin
        if (ticks_left <= TIMER_BITS'(1)) begin
          cycle_active_next   = 1'b0;
          pending_key_next    = 4'd0;
          cycle_position_next = 3'd0;
          ticks_left_next     = '0;
          step_res.action     = ACT_COMMIT;
        end else begin
          ticks_left_next = ticks_left - TIMER_BITS'(1);
        end
      end
    end else if (item.data.is_press && item.data.auto_repeat && keypad) begin
      step_res.handled = 1'b1;
    end else if (!text_entry_allowed) begin
      step_res.handled = 1'b0;
    end else if (item.data.key_class == KEY_ERASE && cycle_active) begin
      step_res.handled = 1'b1;
      if (item.data.is_press) begin
        cycle_active_next   = 1'b0;
        pending_key_next    = 4'd0;
        cycle_position_next = 3'd0;
        ticks_left_next     = '0;
        step_res.action     = ACT_CANCEL;
      end
    end else if (!keypad) begin
      if (cycle_active && item.data.is_press) begin
        cycle_active_next   = 1'b0;
        pending_key_next    = 4'd0;
        cycle_position_next = 3'd0;
        ticks_left_next     = '0;
        step_res.action     = ACT_COMMIT;
      end
    end else if (!item.data.is_press) begin
      step_res.handled = 1'b1;
    end else begin
      step_res.handled = 1'b1;
      if (same_key) begin
        pos_new         = (pos_inc >= CYCLE_LEN[item.data.key_class]) ? 3'd0 : pos_inc;
        step_res.action = ACT_SHOW;
      end else begin
        pos_new         = 3'd0;
        step_res.action = cycle_active ? ACT_COMMIT_SHOW : ACT_SHOW;
      end
      cycle_active_next   = 1'b1;
      pending_key_next    = item.data.key_class;
      cycle_position_next = pos_new;
      ticks_left_next     = TIMER_BITS'(commit_timeout);
      step_res.shown_char = CYCLE_CHARS[item.data.key_class][pos_new];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_active   <= 1'b0;
      pending_key    <= 4'd0;
      cycle_position <= 3'd0;
      ticks_left     <= '0;
    end else if (accept) begin
      cycle_active   <= cycle_active_next;
      pending_key    <= pending_key_next;
      cycle_position <= cycle_position_next;
      ticks_left     <= ticks_left_next;
    end
  end

  // two-entry output buffer, head is the oldest beat
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (pop || !head_valid) begin
        head_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      head_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        head <= skid;
      end
    end else if (accept) begin
      if (pop || !head_valid) begin
        head <= step_res;
      end else begin
        skid <= step_res;
      end
    end
  end

endmodule

[hw/rtl/kmte_checker.sv]
module kmte_checker
  import kmte_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         res_valid,
  input logic         res_ready,
  input kmte_result_t res_data
);

  // a stalled result beat holds
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result beat changed while stalled");

  assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.action != ACT_SHOW && res_data.action != ACT_COMMIT_SHOW
    |-> res_data.shown_char == 7'd0)
    else $error("character shown without a show action");

  // commit alone never consumes the key, cancel always does
  assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_data.action == ACT_COMMIT || res_data.action == ACT_CANCEL)
    |-> res_data.handled == (res_data.action == ACT_CANCEL))
    else $error("handled flag inconsistent with action");

  assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_data.action == ACT_SHOW || res_data.action == ACT_COMMIT_SHOW)
    |-> res_data.handled)
    else $error("show action on a key passed on");

endmodule

bind keypad_multitap_text_entry kmte_checker u_kmte_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_data  (result.data)
);

[tb/tb_keypad_multitap_text_entry.sv]
`timescale 1ns / 1ps

module tb_keypad_multitap_text_entry;
  import kmte_pkg::*;

  typedef struct {
    logic         pinned;
    kmte_result_t res;
  } pin_t;

  typedef struct {
    logic        is_cfg;
    logic        cfg_idx;
    logic [15:0] cfg_val;
    kmte_item_t  it;
    pin_t        pin;
  } row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;

  kmte_item_if   item_ch ();
  kmte_result_if result_ch ();

  keypad_multitap_text_entry u_top (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch.sink),
    .result    (result_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // character lists per digit, the digit itself last
  string keypad_chars [10] = '{" 0", ".,?!1", "abc2", "def3", "ghi4",
                               "jkl5", "mno6", "pqrs7", "tuv8", "wxyz9"};

  // predictor copy of registers and tap state
  logic                  model_text_en;
  logic [15:0]           model_timeout;
  logic                  tap_active;
  logic [3:0]            tap_key;
  logic [2:0]            tap_pos;
  logic [TIMER_BITS-1:0] tap_ticks;

  kmte_result_t expected_q [$];
  pin_t         pin_q [$];
  row_t         plan_q [$];

  int          fail_count;
  int unsigned idle_pct;
  int unsigned hold_asked;
  logic [3:0]  rand_tap_key;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic void drop_pending();
    tap_active = 1'b0;
    tap_key    = '0;
    tap_pos    = '0;
    tap_ticks  = '0;
  endfunction

  function automatic kmte_result_t predict_tap(input kmte_item_t it);
    kmte_result_t r;
    logic         keypad;
    logic [2:0]   nxt;
    string        chars;
    r = '0;
    keypad = (it.key_class <= KEY_LAST_DIGIT);
    if (it.func) begin
      if (tap_active) begin
        if (tap_ticks <= 1) begin
          drop_pending();
          r.action = ACT_COMMIT;
        end else begin
          tap_ticks = tap_ticks - 1'b1;
        end
      end
    end else if (it.is_press && it.auto_repeat && keypad) begin
      r.handled = 1'b1;
    end else if (!model_text_en) begin
      r = '0;
    end else if (it.key_class == KEY_ERASE && tap_active) begin
      r.handled = 1'b1;
      if (it.is_press) begin
        drop_pending();
        r.action = ACT_CANCEL;
      end
    end else if (!keypad) begin
      if (tap_active && it.is_press) begin
        drop_pending();
        r.action = ACT_COMMIT;
      end
    end else if (!it.is_press) begin
      r.handled = 1'b1;
    end else begin
      r.handled = 1'b1;
      chars = keypad_chars[it.key_class];
      if (tap_active && tap_key == it.key_class) begin
        nxt = tap_pos + 3'd1;
        tap_pos = (nxt >= chars.len()) ? 3'd0 : nxt;
        r.action = ACT_SHOW;
      end else begin
        r.action = tap_active ? ACT_COMMIT_SHOW : ACT_SHOW;
        tap_active = 1'b1;
        tap_key = it.key_class;
        tap_pos = '0;
      end
      tap_ticks = TIMER_BITS'(model_timeout);
      r.shown_char = 7'(chars[tap_pos]);
    end
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  function automatic row_t key_row(input logic f, input logic p, input logic [3:0] k,
                                   input logic rep);
    row_t r;
    r = '{default: '0};
    r.it = '{func: f, is_press: p, key_class: k, auto_repeat: rep};
    r.pin.pinned = 1'b0;
    r.pin.res = '0;
    return r;
  endfunction

  function automatic row_t pinned_row(input logic f, input logic p, input logic [3:0] k,
                                      input logic rep, input logic h, input logic [2:0] a,
                                      input byte c);
    row_t r;
    r = key_row(f, p, k, rep);
    r.pin.pinned = 1'b1;
    r.pin.res = '{handled: h, action: a, shown_char: c[6:0]};
    return r;
  endfunction

  function automatic row_t reg_row(input logic idx, input logic [15:0] val);
    row_t r;
    r = key_row(1'b0, 1'b0, 4'd0, 1'b0);
    r.is_cfg = 1'b1;
    r.cfg_idx = idx;
    r.cfg_val = val;
    return r;
  endfunction

  // mostly taps on the current key and ticks, the rest noise
  function automatic kmte_item_t random_event();
    kmte_item_t  it;
    logic [6:0]  raw;
    int unsigned pick;
    raw = 7'($urandom);
    it = '0;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      it.is_press = 1'b1;
      it.key_class = rand_tap_key;
    end else if (pick < 52) begin
      it = raw;
      it.func = 1'b1;
    end else if (pick < 62) begin
      rand_tap_key = 4'($urandom_range(0, 9));
      it.is_press = 1'b1;
      it.key_class = rand_tap_key;
    end else if (pick < 70) begin
      it.key_class = 4'($urandom_range(0, 9));
      it.auto_repeat = raw[0];
    end else if (pick < 77) begin
      it.key_class = KEY_ERASE;
      it.is_press = raw[0];
      it.auto_repeat = raw[1];
    end else if (pick < 85) begin
      it.key_class = 4'($urandom_range(11, 15));
      it.is_press = raw[0];
      it.auto_repeat = raw[1];
    end else if (pick < 92) begin
      it.is_press = 1'b1;
      it.auto_repeat = 1'b1;
      it.key_class = 4'($urandom_range(0, 9));
    end else begin
      it = raw;
    end
    return it;
  endfunction

  task automatic offer(input kmte_item_t it, input pin_t pin);
    int unsigned gap;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      gap = pick_gap();
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.data <= it;
    pin_q.push_back(pin);
    do @(posedge clk); while (!item_ch.ready);
  endtask

  task automatic drain(input int unsigned settle);
    item_ch.valid <= 1'b0;
    while (expected_q.size() != 0 || pin_q.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    drain(2);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TEXT_ENTRY_ALLOWED) model_text_en = val[0];
    else model_timeout = val;
  endtask

  // result side: random back-pressure plus one long hold-off on request
  initial begin : result_sink
    int unsigned hold_served;
    hold_served = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        result_ch.ready <= 1'b0;
      end else if (hold_served != hold_asked) begin
        hold_served = hold_asked;
        result_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        result_ch.ready <= 1'b1;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        result_ch.ready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
        result_ch.ready <= 1'b1;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : scoreboard
    kmte_result_t want;
    kmte_result_t got;
    pin_t         pin;
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        got = result_ch.data;
        if (expected_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual %h", $time, got);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (got.handled !== want.handled) begin
            $display("%0t: handled expected %0d actual %0d", $time, want.handled,
                     got.handled);
            fail_count++;
          end
          if (got.action !== want.action) begin
            $display("%0t: action expected %0d actual %0d", $time, want.action, got.action);
            fail_count++;
          end
          if (got.shown_char !== want.shown_char) begin
            $display("%0t: shown_char expected %h actual %h", $time, want.shown_char,
                     got.shown_char);
            fail_count++;
          end
        end
      end
      if (item_ch.valid && item_ch.ready) begin
        want = predict_tap(item_ch.data);
        pin = pin_q.pop_front();
        if (pin.pinned) want = pin.res;
        expected_q.push_back(want);
      end
    end
  end

  initial begin : watchdog
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    int unsigned ph;
    int unsigned n;
    logic [15:0] tmo;
    rst = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_TEXT_ENTRY_ALLOWED;
    cfg_data = '0;
    fail_count = 0;
    idle_pct = 30;
    hold_asked = 0;
    rand_tap_key = 4'd2;
    model_text_en = 1'b1;
    model_timeout = 16'd1500;
    drop_pending();

    // idle: tick, other key, backspace are all passed on
    plan_q.push_back(pinned_row(1, 0, 4'd0, 0, 0, ACT_NONE, 8'd0));
    plan_q.push_back(pinned_row(0, 1, 4'd11, 0, 0, ACT_NONE, 8'd0));
    plan_q.push_back(pinned_row(0, 1, KEY_ERASE, 0, 0, ACT_NONE, 8'd0));
    // tap 2 five times, wraps back to a
    plan_q.push_back(pinned_row(0, 1, 4'd2, 0, 1, ACT_SHOW, "a"));
    plan_q.push_back(key_row(0, 1, 4'd2, 0));
    plan_q.push_back(key_row(0, 1, 4'd2, 0));
    plan_q.push_back(key_row(0, 1, 4'd2, 0));
    plan_q.push_back(key_row(0, 1, 4'd2, 0));
    plan_q.push_back(key_row(0, 0, 4'd2, 0));
    // auto-repeat digit swallowed
    plan_q.push_back(pinned_row(0, 1, 4'd3, 1, 1, ACT_NONE, 8'd0));
    plan_q.push_back(pinned_row(0, 1, 4'd9, 0, 1, ACT_COMMIT_SHOW, "w"));
    plan_q.push_back(key_row(0, 0, KEY_ERASE, 0));
    plan_q.push_back(pinned_row(0, 1, KEY_ERASE, 0, 1, ACT_CANCEL, 8'd0));
    plan_q.push_back(key_row(0, 1, 4'd0, 0));
    plan_q.push_back(key_row(0, 1, 4'd0, 0));
    // other key release keeps the pending char, press commits it
    plan_q.push_back(key_row(0, 0, 4'd15, 0));
    plan_q.push_back(key_row(0, 1, 4'd12, 0));
    plan_q.push_back(key_row(0, 1, 4'd1, 0));
    plan_q.push_back(key_row(0, 1, 4'd11, 1));
    plan_q.push_back(reg_row(CFG_COMMIT_TIMEOUT, 16'd1));
    plan_q.push_back(key_row(0, 1, 4'd7, 0));
    plan_q.push_back(pinned_row(1, 1, 4'd15, 1, 0, ACT_COMMIT, 8'd0));
    // zero timeout commits on the first tick
    plan_q.push_back(reg_row(CFG_COMMIT_TIMEOUT, 16'd0));
    plan_q.push_back(key_row(0, 1, 4'd8, 0));
    plan_q.push_back(pinned_row(1, 0, 4'd0, 0, 0, ACT_COMMIT, 8'd0));
    // text entry off with a char pending: timer keeps running
    plan_q.push_back(reg_row(CFG_COMMIT_TIMEOUT, 16'd2));
    plan_q.push_back(key_row(0, 1, 4'd5, 0));
    plan_q.push_back(reg_row(CFG_TEXT_ENTRY_ALLOWED, 16'd0));
    plan_q.push_back(pinned_row(0, 1, 4'd6, 0, 0, ACT_NONE, 8'd0));
    plan_q.push_back(pinned_row(0, 1, 4'd6, 1, 1, ACT_NONE, 8'd0));
    plan_q.push_back(key_row(1, 0, 4'd0, 0));
    plan_q.push_back(pinned_row(1, 0, 4'd0, 0, 0, ACT_COMMIT, 8'd0));
    plan_q.push_back(reg_row(CFG_TEXT_ENTRY_ALLOWED, 16'd1));

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan_q[i]) begin
      if (plan_q[i].is_cfg) write_reg(plan_q[i].cfg_idx, plan_q[i].cfg_val);
      else offer(plan_q[i].it, plan_q[i].pin);
    end

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: tmo = 16'd3;
        1: tmo = 16'hffff;
        2: tmo = 16'd5;
        3: tmo = 16'd0;
        4: tmo = 16'($urandom_range(1, 12));
        default: tmo = 16'd1;
      endcase
      write_reg(CFG_TEXT_ENTRY_ALLOWED, (ph == 2) ? 16'd0 : 16'd1);
      write_reg(CFG_COMMIT_TIMEOUT, tmo);
      idle_pct = (ph == 1 || ph == 4) ? 0 : 30;
      // hold results back while items keep coming, so the input stalls
      if (ph == 1) hold_asked++;
      for (n = 0; n < 75; n++) begin
        if (ph == 3 && n == 37) drain(0);
        offer(random_event(), '{pinned: 1'b0, res: '0});
      end
    end

    drain(10);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[keypad_multitap_text_entry.f]
hw/rtl/kmte_pkg.sv
hw/rtl/kmte_item_if.sv
hw/rtl/kmte_result_if.sv
hw/rtl/keypad_multitap_text_entry.sv
hw/rtl/kmte_checker.sv
tb/tb_keypad_multitap_text_entry.sv
